>>> sv/mbpa_pkg.sv
package mbpa_pkg;

    localparam int PAGES_PER_BLOCK = 64;
    localparam int MAX_BLOCKS      = 16;

    // Field widths of the ports.
    localparam int OFF_W      = 18;
    localparam int PS_W       = 13;
    localparam int INIT_W     = 5;
    localparam int BLKNUM_W   = 4;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // Derived widths.
    localparam int IDX_W  = $clog2(PAGES_PER_BLOCK);
    localparam int HINT_W = $clog2(PAGES_PER_BLOCK + 1);
    localparam int BLK_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int DIV_W  = (OFF_W > PS_W + IDX_W) ? OFF_W : PS_W + IDX_W;
    localparam int DCNT_W = $clog2(IDX_W + 1);
    localparam int PROD_W = PS_W + IDX_W;

    // The hint search looks at one aligned group of bits per cycle.
    localparam int SRCH_SH    = 3;
    localparam int SRCH_LANES = 1 << SRCH_SH;
    localparam int POS_W      = $clog2(PAGES_PER_BLOCK + SRCH_LANES);

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_BLOCKS = 1'd1;

    localparam logic [PS_W-1:0]   PAGE_SIZE_RST   = 13'd4096;
    localparam logic [INIT_W-1:0] INIT_BLOCKS_RST = 5'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RUN,
        S_MUL,
        S_DONE
    } state_t;

    // Request that walks down the row of block cells, one cell per cycle.
    typedef struct packed {
        logic             valid;
        logic             is_free;
        logic [BLK_W-1:0] pos;
        logic [BLK_W-1:0] free_blk;
        logic [IDX_W-1:0] free_idx;
        logic             pending;
        logic             attempted;
        logic             opened;
        logic [BLK_W-1:0] gblk;
        logic [IDX_W-1:0] gidx;
    } tok_t;

endpackage

>>> sv/mbpa_div.sv
module mbpa_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mbpa_pkg::OFF_W-1:0]  dividend,
    input  logic [mbpa_pkg::PS_W-1:0]   divisor,
    output logic                        done,
    output logic                        over,
    output logic [mbpa_pkg::IDX_W-1:0]  quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [mbpa_pkg::DCNT_W-1:0]   cnt_reg;
    logic [mbpa_pkg::DIV_W-1:0]    rem_reg;
    logic [mbpa_pkg::DIV_W-1:0]    dsh_reg;
    logic [mbpa_pkg::IDX_W-1:0]    q_reg;
    logic                          over_reg;

    logic [mbpa_pkg::DIV_W-1:0]    limit;
    logic                          start_over;
    logic                          fits;

    // A quotient at or above the page count is only flagged, never computed.
    assign limit      = mbpa_pkg::DIV_W'(divisor)
                        * mbpa_pkg::DIV_W'(mbpa_pkg::PAGES_PER_BLOCK);
    assign start_over = mbpa_pkg::DIV_W'(dividend) >= limit;
    assign fits       = rem_reg >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= !start_over;
                done_reg <= start_over;
                cnt_reg  <= mbpa_pkg::DCNT_W'(mbpa_pkg::IDX_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            over_reg <= start_over;
            rem_reg  <= mbpa_pkg::DIV_W'(dividend);
            dsh_reg  <= mbpa_pkg::DIV_W'(divisor) << (mbpa_pkg::IDX_W - 1);
            q_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= (q_reg << 1) | mbpa_pkg::IDX_W'(fits);
        end
    end

    assign done     = done_reg;
    assign over     = over_reg;
    assign quotient = q_reg;

endmodule

>>> sv/mbpa_cell.sv
module mbpa_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mbpa_pkg::tok_t              tok_in,
    input  logic [mbpa_pkg::CNT_W-1:0]  open_cnt,
    output mbpa_pkg::tok_t              tok_out,
    output logic                        busy
);

    logic [mbpa_pkg::PAGES_PER_BLOCK-1:0] bitmap_reg;
    logic [mbpa_pkg::PAGES_PER_BLOCK-1:0] bitmap_next;
    logic [mbpa_pkg::HINT_W-1:0]          hint_reg;
    logic [mbpa_pkg::HINT_W-1:0]          hint_next;
    logic                                 busy_reg;
    logic                                 busy_next;
    mbpa_pkg::tok_t                       tok_out_reg;
    mbpa_pkg::tok_t                       tok_out_next;

    logic [mbpa_pkg::CNT_W-1:0] pos_ext;
    logic                       alloc_here;
    logic                       at_open;
    logic                       hit_alloc;
    logic                       hit_free;

    assign pos_ext    = mbpa_pkg::CNT_W'(tok_in.pos);
    assign alloc_here = tok_in.valid && !tok_in.is_free && tok_in.pending
                        && (pos_ext <= open_cnt);
    assign at_open    = pos_ext == open_cnt;
    assign hit_alloc  = alloc_here && (32'(hint_reg) < mbpa_pkg::PAGES_PER_BLOCK);
    assign hit_free   = tok_in.valid && tok_in.is_free && (tok_in.pos == tok_in.free_blk);

    always_comb
    begin : next_logic
        logic [mbpa_pkg::POS_W-1:0]   hp;
        logic [mbpa_pkg::POS_W-1:0]   base;
        logic [mbpa_pkg::POS_W-1:0]   lane_lo;
        logic [mbpa_pkg::POS_W-1:0]   p;
        logic [mbpa_pkg::POS_W-1:0]   nxt;
        logic [mbpa_pkg::POS_W-1:0]   hit_pos;
        logic                         found;

        bitmap_next  = bitmap_reg;
        hint_next    = hint_reg;
        busy_next    = busy_reg;
        tok_out_next = tok_in;
        tok_out_next.pos = tok_in.pos + 1'b1;

        hp      = mbpa_pkg::POS_W'(hint_reg);
        base    = hp & ~mbpa_pkg::POS_W'(mbpa_pkg::SRCH_LANES - 1);
        lane_lo = mbpa_pkg::POS_W'(hp[mbpa_pkg::SRCH_SH-1:0]);
        nxt     = base + mbpa_pkg::POS_W'(mbpa_pkg::SRCH_LANES);
        found   = 1'b0;
        hit_pos = '0;
        p       = '0;

        // Scan downward so the lowest clear bit of the group wins.
        for (int k = mbpa_pkg::SRCH_LANES - 1; k >= 0; k--)
        begin
            p = base + mbpa_pkg::POS_W'(k);
            if (mbpa_pkg::POS_W'(k) >= lane_lo
                && 32'(p) < mbpa_pkg::PAGES_PER_BLOCK
                && !bitmap_reg[p[mbpa_pkg::IDX_W-1:0]])
            begin
                found   = 1'b1;
                hit_pos = p;
            end
        end

        if (busy_reg)
        begin
            if (found)
            begin
                hint_next = mbpa_pkg::HINT_W'(hit_pos);
                busy_next = 1'b0;
            end
            else if (32'(nxt) >= mbpa_pkg::PAGES_PER_BLOCK)
            begin
                hint_next = mbpa_pkg::HINT_W'(mbpa_pkg::PAGES_PER_BLOCK);
                busy_next = 1'b0;
            end
            else
            begin
                hint_next = mbpa_pkg::HINT_W'(nxt);
            end
        end

        if (alloc_here && at_open)
        begin
            tok_out_next.attempted = 1'b1;
        end

        if (hit_alloc)
        begin
            bitmap_next[hint_reg[mbpa_pkg::IDX_W-1:0]] = 1'b1;
            hint_next            = hint_reg + 1'b1;
            busy_next            = (32'(hint_reg) + 1) < mbpa_pkg::PAGES_PER_BLOCK;
            tok_out_next.pending = 1'b0;
            tok_out_next.opened  = at_open;
            tok_out_next.gblk    = tok_in.pos;
            tok_out_next.gidx    = hint_reg[mbpa_pkg::IDX_W-1:0];
        end

        if (hit_free)
        begin
            bitmap_next[tok_in.free_idx] = 1'b0;
            if (mbpa_pkg::HINT_W'(tok_in.free_idx) < hint_reg)
            begin
                hint_next = mbpa_pkg::HINT_W'(tok_in.free_idx);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitmap_reg  <= '0;
            hint_reg    <= '0;
            busy_reg    <= 1'b0;
            tok_out_reg <= '0;
        end
        else
        begin
            bitmap_reg  <= bitmap_next;
            hint_reg    <= hint_next;
            busy_reg    <= busy_next;
            tok_out_reg <= tok_out_next;
        end
    end

    assign tok_out = tok_out_reg;
    assign busy    = busy_reg;

    a_busy_hint_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (32'(hint_reg) < mbpa_pkg::PAGES_PER_BLOCK))
        else $error("hint search running with hint past the block");

    a_hint_is_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy_reg && 32'(hint_reg) < mbpa_pkg::PAGES_PER_BLOCK)
        |-> !bitmap_reg[hint_reg[mbpa_pkg::IDX_W-1:0]])
        else $error("settled hint points at a used page");

    a_alloc_marks_page: assert property (@(posedge clk) disable iff (!rst_n)
        hit_alloc |=> (bitmap_reg[$past(hint_reg[mbpa_pkg::IDX_W-1:0])]
                       && !tok_out_reg.pending))
        else $error("granted page not marked used");

endmodule

>>> sv/multi_block_page_allocator_top.sv
// Channel   Direction  Signals
// in        input      in_valid, in_ready, action, block_number, byte_offset
// out       output     out_valid, out_ready, granted_block, granted_offset,
//                      opened_block, status
// cfg       input      cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One item is handled at a time. A granted allocate walks the row of block cells
// one cell per cycle, then the offset is multiplied in the multiply state. A
// refused allocate skips the multiply. A free first runs the quotient loop, one
// bit per cycle, then walks the row without the multiply. A free past the block
// end is flagged by the divider's range check and skips the row; one of an
// unopened block or with a zero page size skips the divider as well.
// After a grant the next item waits until that block's hint search has settled.
// The result sits in an output register, so a new item is accepted while it
// waits for out_ready. Reset clears all bitmaps and hints at once.
module multi_block_page_allocator_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             action,
    input  logic [mbpa_pkg::BLKNUM_W-1:0]    block_number,
    input  logic [mbpa_pkg::OFF_W-1:0]       byte_offset,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [mbpa_pkg::BLKNUM_W-1:0]    granted_block,
    output logic [mbpa_pkg::OFF_W-1:0]       granted_offset,
    output logic                             opened_block,
    output logic [mbpa_pkg::STAT_W-1:0]      status,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mbpa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    mbpa_pkg::state_t                  state_reg;
    mbpa_pkg::state_t                  state_next;

    logic [mbpa_pkg::PS_W-1:0]         page_size_reg;
    logic [mbpa_pkg::INIT_W-1:0]       initial_blocks_reg;
    logic [mbpa_pkg::CNT_W-1:0]        blocks_opened_reg;

    logic                              op_free_reg;
    logic [mbpa_pkg::BLK_W-1:0]        free_blk_reg;
    logic [mbpa_pkg::BLKNUM_W-1:0]     res_block_reg;
    logic [mbpa_pkg::IDX_W-1:0]        res_idx_reg;
    logic [mbpa_pkg::OFF_W-1:0]        res_offset_reg;
    logic                              res_opened_reg;
    logic [mbpa_pkg::STAT_W-1:0]       res_status_reg;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [mbpa_pkg::BLKNUM_W-1:0]     granted_block_reg;
    logic [mbpa_pkg::OFF_W-1:0]        granted_offset_reg;
    logic                              opened_block_reg;
    logic [mbpa_pkg::STAT_W-1:0]       status_reg;

    logic [mbpa_pkg::CNT_W-1:0]        init_sat;
    logic [mbpa_pkg::CNT_W-1:0]        open_cnt;
    logic                              acc;
    logic                              pre_invalid;
    logic                              search_busy;
    logic                              load_out;
    logic                              div_start;
    logic                              div_done;
    logic                              div_over;
    logic [mbpa_pkg::IDX_W-1:0]        div_q;
    logic [mbpa_pkg::PROD_W-1:0]       product;

    mbpa_pkg::tok_t                    chain_tok [mbpa_pkg::MAX_BLOCKS+1];
    logic [mbpa_pkg::MAX_BLOCKS-1:0]   cell_busy;
    mbpa_pkg::tok_t                    chain_out;

    assign init_sat = (32'(initial_blocks_reg) > mbpa_pkg::MAX_BLOCKS)
                      ? mbpa_pkg::CNT_W'(mbpa_pkg::MAX_BLOCKS)
                      : mbpa_pkg::CNT_W'(initial_blocks_reg);
    assign open_cnt = (blocks_opened_reg > init_sat) ? blocks_opened_reg : init_sat;

    assign acc         = in_valid && in_ready;
    assign pre_invalid = (page_size_reg == '0) || (32'(block_number) >= 32'(open_cnt));
    assign search_busy = |cell_busy;
    assign chain_out   = chain_tok[mbpa_pkg::MAX_BLOCKS];
    assign product     = mbpa_pkg::PROD_W'(res_idx_reg) * mbpa_pkg::PROD_W'(page_size_reg);

    mbpa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (byte_offset),
        .divisor  (page_size_reg),
        .done     (div_done),
        .over     (div_over),
        .quotient (div_q)
    );

    for (genvar i = 0; i < mbpa_pkg::MAX_BLOCKS; i++)
    begin : g_cell
        mbpa_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tok_in   (chain_tok[i]),
            .open_cnt (open_cnt),
            .tok_out  (chain_tok[i+1]),
            .busy     (cell_busy[i])
        );
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mbpa_pkg::S_IDLE:
            begin
                if (acc)
                begin
                    if (action == mbpa_pkg::ACT_ALLOC)
                    begin
                        state_next = mbpa_pkg::S_RUN;
                    end
                    else if (pre_invalid)
                    begin
                        state_next = mbpa_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = mbpa_pkg::S_DIV;
                    end
                end
            end
            mbpa_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = div_over ? mbpa_pkg::S_DONE : mbpa_pkg::S_RUN;
                end
            end
            mbpa_pkg::S_RUN:
            begin
                if (chain_out.valid)
                begin
                    state_next = (!chain_out.is_free && !chain_out.pending)
                                 ? mbpa_pkg::S_MUL : mbpa_pkg::S_DONE;
                end
            end
            mbpa_pkg::S_MUL:
            begin
                state_next = mbpa_pkg::S_DONE;
            end
            mbpa_pkg::S_DONE:
            begin
                if (load_out)
                begin
                    state_next = mbpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mbpa_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        in_ready     = 1'b0;
        div_start    = 1'b0;
        load_out     = 1'b0;
        chain_tok[0] = '0;
        case (state_reg)
            mbpa_pkg::S_IDLE:
            begin
                in_ready = !search_busy;
                if (acc)
                begin
                    if (action == mbpa_pkg::ACT_ALLOC)
                    begin
                        chain_tok[0].valid   = 1'b1;
                        chain_tok[0].pending = 1'b1;
                    end
                    else if (!pre_invalid)
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            mbpa_pkg::S_DIV:
            begin
                if (div_done && !div_over)
                begin
                    chain_tok[0].valid    = 1'b1;
                    chain_tok[0].is_free  = 1'b1;
                    chain_tok[0].free_blk = free_blk_reg;
                    chain_tok[0].free_idx = div_q;
                end
            end
            mbpa_pkg::S_RUN:
            begin
                chain_tok[0] = '0;
            end
            mbpa_pkg::S_MUL:
            begin
                chain_tok[0] = '0;
            end
            mbpa_pkg::S_DONE:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                chain_tok[0] = '0;
            end
        endcase
    end

    assign out_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= mbpa_pkg::S_IDLE;
            out_valid_reg      <= 1'b0;
            page_size_reg      <= mbpa_pkg::PAGE_SIZE_RST;
            initial_blocks_reg <= mbpa_pkg::INIT_BLOCKS_RST;
            blocks_opened_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mbpa_pkg::CFG_PAGE_SIZE:
                    begin
                        page_size_reg <= cfg_data[mbpa_pkg::PS_W-1:0];
                    end
                    mbpa_pkg::CFG_INIT_BLOCKS:
                    begin
                        initial_blocks_reg <= cfg_data[mbpa_pkg::INIT_W-1:0];
                    end
                    default:
                    begin
                        page_size_reg <= page_size_reg;
                    end
                endcase
            end
            // An attempt to open a new block counts even when that block is full.
            if (state_reg == mbpa_pkg::S_RUN && chain_out.valid && chain_out.attempted)
            begin
                blocks_opened_reg <= open_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            mbpa_pkg::S_IDLE:
            begin
                if (acc)
                begin
                    op_free_reg    <= action;
                    free_blk_reg   <= mbpa_pkg::BLK_W'(block_number);
                    res_block_reg  <= '0;
                    res_idx_reg    <= '0;
                    res_offset_reg <= '0;
                    res_opened_reg <= 1'b0;
                    res_status_reg <= (action == mbpa_pkg::ACT_FREE && pre_invalid)
                                      ? mbpa_pkg::ST_BAD_FREE : mbpa_pkg::ST_OK;
                end
            end
            mbpa_pkg::S_DIV:
            begin
                if (div_done && div_over)
                begin
                    res_status_reg <= mbpa_pkg::ST_BAD_FREE;
                end
            end
            mbpa_pkg::S_RUN:
            begin
                if (chain_out.valid && op_free_reg == mbpa_pkg::ACT_ALLOC)
                begin
                    if (chain_out.pending)
                    begin
                        res_status_reg <= mbpa_pkg::ST_FULL;
                    end
                    else
                    begin
                        res_block_reg  <= mbpa_pkg::BLKNUM_W'(chain_out.gblk);
                        res_idx_reg    <= chain_out.gidx;
                        res_opened_reg <= chain_out.opened;
                    end
                end
            end
            mbpa_pkg::S_MUL:
            begin
                res_offset_reg <= mbpa_pkg::OFF_W'(product);
            end
            mbpa_pkg::S_DONE:
            begin
                if (load_out)
                begin
                    granted_block_reg  <= res_block_reg;
                    granted_offset_reg <= res_offset_reg;
                    opened_block_reg   <= res_opened_reg;
                    status_reg         <= res_status_reg;
                end
            end
            default:
            begin
                res_status_reg <= res_status_reg;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign granted_block  = granted_block_reg;
    assign granted_offset = granted_offset_reg;
    assign opened_block   = opened_block_reg;
    assign status         = status_reg;
    assign cfg_ready      = 1'b1;

    a_chain_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        chain_out.valid |-> (state_reg == mbpa_pkg::S_RUN))
        else $error("request left the cell row outside the run state");

    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == mbpa_pkg::S_DIV))
        else $error("quotient finished outside the divide state");

    a_open_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(blocks_opened_reg) <= mbpa_pkg::MAX_BLOCKS)
        else $error("more blocks opened than exist");

endmodule
